FILE: design/bbm_pkg.sv
// ----------------------------------------------------------------------------
// bbm_pkg
// shared types, constants and the reciprocal table for the 3x3 mean filter
// ----------------------------------------------------------------------------
package bbm_pkg;

    localparam int CH_W          = 8;
    localparam int CFG_DATA_W    = 12;
    localparam int CFG_IDX_W     = 2;
    localparam int ROW_W         = CFG_DATA_W + 1;
    localparam int SUM_W         = 12;
    localparam int CNT_W         = 4;
    localparam int RECIP_W       = 16;
    localparam int RECIP_SHIFT   = 15;
    localparam int DEF_MAX_WIDTH = 2048;

    localparam logic [CFG_DATA_W-1:0] IMAGE_WIDTH_RST = CFG_DATA_W'(640);
    localparam logic [CFG_DATA_W-1:0] FRAME_ROWS_RST  = CFG_DATA_W'(240);

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS  = CFG_IDX_W'(1);

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [SUM_W-1:0] sum_blue;
        logic [SUM_W-1:0] sum_green;
        logic [SUM_W-1:0] sum_red;
        logic [CNT_W-1:0] cnt;
        logic             frame_end;
    } t_mean_req;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV
    } t_state;

    // ceil(2^15 / d); exact floor division for sums up to 9*255
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] d);
        logic [RECIP_W-1:0] m;
        case (d)
            4'd2:    m = 16'd16384;
            4'd3:    m = 16'd10923;
            4'd4:    m = 16'd8192;
            4'd5:    m = 16'd6554;
            4'd6:    m = 16'd5462;
            4'd7:    m = 16'd4682;
            4'd8:    m = 16'd4096;
            4'd9:    m = 16'd3641;
            default: m = 16'd32768;
        endcase
        return m;
    endfunction

endpackage

FILE: design/bbm_line_store.sv
// ----------------------------------------------------------------------------
// bbm_line_store
// two row memories; a write shifts the middle row entry into the upper one
// ----------------------------------------------------------------------------
module bbm_line_store
    import bbm_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    localparam int COL_W    = $clog2(MAX_WIDTH)
) (
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic             i_wr_en,
    input  logic [COL_W-1:0] i_addr,
    input  t_pixel           i_wr_px,
    output t_pixel           o_up,
    output t_pixel           o_mid
);

    t_pixel r_mem_up  [MAX_WIDTH];
    t_pixel r_mem_mid [MAX_WIDTH];
    t_pixel r_up;
    t_pixel r_mid;

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_up  <= r_mem_up[i_addr];
            r_mid <= r_mem_mid[i_addr];
        end
    end

    // write back uses the data read for the same column
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem_up[i_addr]  <= r_mid;
            r_mem_mid[i_addr] <= i_wr_px;
        end
    end

    assign o_up  = r_up;
    assign o_mid = r_mid;

endmodule

FILE: design/bbm_mean_out.sv
// ----------------------------------------------------------------------------
// bbm_mean_out
// divide by neighbor count through a reciprocal multiply, hold the result beat
// ----------------------------------------------------------------------------
module bbm_mean_out
    import bbm_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  t_mean_req       i_req,
    output logic            o_busy,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [CH_W-1:0] o_out_blue,
    output logic [CH_W-1:0] o_out_green,
    output logic [CH_W-1:0] o_out_red,
    output logic            o_frame_end
);

    localparam int PROD_W = SUM_W + RECIP_W;

    logic [RECIP_W-1:0] m;
    logic [PROD_W-1:0]  prod_b;
    logic [PROD_W-1:0]  prod_g;
    logic [PROD_W-1:0]  prod_r;

    logic            r_valid;
    logic [CH_W-1:0] r_blue;
    logic [CH_W-1:0] r_green;
    logic [CH_W-1:0] r_red;
    logic            r_end;

    always_comb begin
        m      = recip(i_req.cnt);
        prod_b = PROD_W'(i_req.sum_blue) * PROD_W'(m);
        prod_g = PROD_W'(i_req.sum_green) * PROD_W'(m);
        prod_r = PROD_W'(i_req.sum_red) * PROD_W'(m);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_blue  <= prod_b[RECIP_SHIFT +: CH_W];
            r_green <= prod_g[RECIP_SHIFT +: CH_W];
            r_red   <= prod_r[RECIP_SHIFT +: CH_W];
            r_end   <= i_req.frame_end;
        end
    end

    assign o_busy      = r_valid && i_out_stall;
    assign o_out_valid = r_valid;
    assign o_out_blue  = r_blue;
    assign o_out_green = r_green;
    assign o_out_red   = r_red;
    assign o_frame_end = r_end;

endmodule

FILE: design/box_blur_3x3_mean.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_mean
// 3x3 mean filter over a raster bgr stream, neighborhood clipped to the frame
// steps: line store read and pixel register, then window sums, then reciprocal
//   multiply into the held result beat; a new pixel beat is taken only once the
//   previous beat has left these steps, which waits while the output stalls
// reset: synchronous active low; registers at 640 x 240, window and counters
//   zero; line store contents stay undefined, never used outside the frame
// ----------------------------------------------------------------------------
module box_blur_3x3_mean
    import bbm_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // pixel / drain beats
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_kind,
    input  logic [CH_W-1:0]       i_in_blue,
    input  logic [CH_W-1:0]       i_in_green,
    input  logic [CH_W-1:0]       i_in_red,
    // result beats
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [CH_W-1:0]       o_out_blue,
    output logic [CH_W-1:0]       o_out_green,
    output logic [CH_W-1:0]       o_out_red,
    output logic                  o_frame_end,
    // register writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WCNT_W = $clog2(MAX_WIDTH + 1);
    localparam int W_RST  = (int'(IMAGE_WIDTH_RST) > MAX_WIDTH) ? MAX_WIDTH
                                                                : int'(IMAGE_WIDTH_RST);

    // effective frame size, clamped at write time
    logic [WCNT_W-1:0]     r_w_eff;
    logic [CFG_DATA_W-1:0] r_h_eff;

    // position counters
    logic [COL_W-1:0]      r_in_col, n_in_col;
    logic [ROW_W-1:0]      r_in_row, n_in_row;
    logic [COL_W-1:0]      r_out_col, n_out_col;
    logic [CFG_DATA_W-1:0] r_out_row, n_out_row;

    t_state r_state, n_state;

    // window: only the two previous columns are kept, the new column comes
    // straight from the line store read and the registered pixel
    t_pixel r_win_l [3];
    t_pixel r_win_c [3];
    t_pixel r_px;
    t_pixel rd_up;
    t_pixel rd_mid;

    t_mean_req r_req, n_req;

    logic in_acc;
    logic draining;
    logic act;
    logic rd_en;
    logic wr_en;
    logic cfg_acc;
    logic cfg_hit;
    logic emit;
    logic last;
    logic load;
    logic out_busy;

    logic [WCNT_W-1:0] col_inc;
    logic [WCNT_W-1:0] ocol_inc;
    logic [ROW_W-1:0]  orow_inc;
    logic [2:0]        row_v;
    logic [2:0]        col_v;
    t_pixel            cells [3][3];

    assign draining = r_in_row >= {1'b0, r_h_eff};
    assign in_acc   = i_in_valid && !o_in_stall;
    // a drain beat inside the frame is dropped, any beat while draining counts
    assign act      = in_acc && (draining || !i_kind);
    assign rd_en    = act;
    assign wr_en    = (r_state == ST_READ);
    assign cfg_acc  = i_cfg_valid && o_cfg_ready;
    // only a write to a real register restarts the frame
    assign cfg_hit  = cfg_acc && (i_cfg_index inside {REG_IMAGE_WIDTH, REG_FRAME_ROWS});
    assign load     = (r_state == ST_DIV) && !out_busy;

    // ---------------- state machine ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (act) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = emit ? ST_DIV : ST_IDLE;
            end
            ST_DIV: begin
                if (!out_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall  = 1'b1;
        o_cfg_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                // a pending register write goes ahead of the pixel beat
                o_in_stall  = i_cfg_valid;
                o_cfg_ready = 1'b1;
            end
            ST_READ, ST_DIV: begin
                o_in_stall  = 1'b1;
                o_cfg_ready = 1'b0;
            end
            default: begin
                o_in_stall  = 1'b1;
                o_cfg_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- line store ----------------
    bbm_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_rd_en (rd_en),
        .i_wr_en (wr_en),
        .i_addr  (r_in_col),
        .i_wr_px (r_px),
        .o_up    (rd_up),
        .o_mid   (rd_mid)
    );

    // pixel of the beat; zero while draining
    always_ff @(posedge i_clk) begin
        if (act) begin
            r_px <= draining ? t_pixel'('0)
                             : t_pixel'{red: i_in_red, green: i_in_green, blue: i_in_blue};
        end
    end

    // ---------------- counters ----------------
    // results lag the input by one row plus one pixel
    assign emit     = (r_in_row >= ROW_W'(2)) || ((r_in_row == ROW_W'(1)) && (r_in_col != '0));
    assign col_inc  = WCNT_W'(r_in_col) + WCNT_W'(1);
    assign ocol_inc = WCNT_W'(r_out_col) + WCNT_W'(1);
    assign orow_inc = ROW_W'(r_out_row) + ROW_W'(1);
    assign last     = (orow_inc >= {1'b0, r_h_eff}) && (ocol_inc >= r_w_eff);

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (col_inc >= r_w_eff) begin
            n_in_col = '0;
            n_in_row = r_in_row + ROW_W'(1);
        end else begin
            n_in_col = col_inc[COL_W-1:0];
        end
        if (emit) begin
            if (last) begin
                // frame done, next frame starts from the top
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
            end else if (ocol_inc >= r_w_eff) begin
                n_out_col = '0;
                n_out_row = r_out_row + CFG_DATA_W'(1);
            end else begin
                n_out_col = ocol_inc[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (cfg_hit) begin
            // a write to a real register restarts the frame
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (r_state == ST_READ) begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_eff <= WCNT_W'(W_RST);
            r_h_eff <= FRAME_ROWS_RST;
        end else if (cfg_acc) begin
            case (i_cfg_index)
                REG_IMAGE_WIDTH: begin
                    if (i_cfg_data == '0) begin
                        r_w_eff <= WCNT_W'(1);
                    end else if (int'(i_cfg_data) > MAX_WIDTH) begin
                        r_w_eff <= WCNT_W'(MAX_WIDTH);
                    end else begin
                        r_w_eff <= WCNT_W'(i_cfg_data);
                    end
                end
                REG_FRAME_ROWS: begin
                    r_h_eff <= (i_cfg_data == '0) ? CFG_DATA_W'(1) : i_cfg_data;
                end
                default: begin
                    // unmapped index, write ignored
                end
            endcase
        end
    end

    // ---------------- window and sums ----------------
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            cells[k][0] = r_win_l[k];
            cells[k][1] = r_win_c[k];
        end
        cells[0][2] = rd_up;
        cells[1][2] = rd_mid;
        cells[2][2] = r_px;
    end

    // clip to the frame around the output position; at a row start the right
    // column falls outside since the output sits on the last column
    assign row_v = {orow_inc < {1'b0, r_h_eff}, 1'b1, r_out_row != '0};
    assign col_v = {ocol_inc < r_w_eff, 1'b1, r_out_col != '0};

    always_comb begin
        n_req           = '0;
        n_req.frame_end = last;
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                if (row_v[k] && col_v[j]) begin
                    n_req.sum_blue  = n_req.sum_blue  + SUM_W'(cells[k][j].blue);
                    n_req.sum_green = n_req.sum_green + SUM_W'(cells[k][j].green);
                    n_req.sum_red   = n_req.sum_red   + SUM_W'(cells[k][j].red);
                    n_req.cnt       = n_req.cnt + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_win_l[k] <= '0;
                r_win_c[k] <= '0;
            end
        end else if (r_state == ST_READ) begin
            for (int k = 0; k < 3; k++) begin
                r_win_l[k] <= r_win_c[k];
                r_win_c[k] <= cells[k][2];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_READ) && emit) begin
            r_req <= n_req;
        end
    end

    // ---------------- divide and output beat ----------------
    bbm_mean_out u_mean_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_req       (r_req),
        .o_busy      (out_busy),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_blue  (o_out_blue),
        .o_out_green (o_out_green),
        .o_out_red   (o_out_red),
        .o_frame_end (o_frame_end)
    );

endmodule
